// ----- hw/rtl/iirdf1_pkg.sv -----
// Shared types, widths and register indexes of the direct form I IIR filter.
package iirdf1_pkg;

  // Field and datapath widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 18;
  localparam int HIST_W   = 32;
  localparam int ORDER_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int FF_PROD_W = SAMPLE_W + COEF_W;   // x * ff_coef
  localparam int FB_PROD_W = HIST_W + COEF_W;     // y * fb_coef
  localparam int ACC_W     = FB_PROD_W + 4;       // headroom for five terms
  localparam int FF_SHIFT  = 8;                   // Q.14 * int -> Q.22
  localparam int HIST_FRAC = 14;                  // Q.22 -> Q23.8
  localparam int OUT_FRAC  = 22;                  // Q.22 -> integer
  localparam int NUM_TAPS  = 3;                   // feedforward coefficient slots; feedback has one fewer

  // Reset value of the current-input coefficient (1.0 in Q3.14)
  localparam logic signed [COEF_W-1:0] FF_COEF_0_RST = 18'sd16384;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYPASS       = 3'd0,
    CFG_FILTER_ORDER = 3'd1,
    CFG_FF_COEF_0    = 3'd2,
    CFG_FF_COEF_1    = 3'd3,
    CFG_FF_COEF_2    = 3'd4,
    CFG_FB_COEF_1    = 3'd5,
    CFG_FB_COEF_2    = 3'd6
  } cfg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [HIST_W-1:0]   hist_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Truncated and saturated results of one accumulator value
  typedef struct packed {
    hist_t   hist;
    sample_t y;
  } sat_res_t;

endpackage

// ----- hw/rtl/iirdf1_sat.sv -----
// Truncation toward zero and saturation of the accumulator to history and output.
module iirdf1_sat (
  input  iirdf1_pkg::acc_t     acc,
  output iirdf1_pkg::sat_res_t res
);

  localparam int ACC_W   = iirdf1_pkg::ACC_W;
  localparam int HIST_W  = iirdf1_pkg::HIST_W;
  localparam int SMP_W   = iirdf1_pkg::SAMPLE_W;
  localparam int HFRAC   = iirdf1_pkg::HIST_FRAC;
  localparam int OFRAC   = iirdf1_pkg::OUT_FRAC;
  localparam int HQ_W    = ACC_W - HFRAC;
  localparam int OQ_W    = ACC_W - OFRAC;

  logic signed [ACC_W-1:0] hbias;
  logic signed [ACC_W-1:0] obias;
  logic signed [ACC_W-1:0] hsum;
  logic signed [ACC_W-1:0] osum;
  logic signed [HQ_W-1:0]  hq;
  logic signed [OQ_W-1:0]  oq;

  // Bias negatives by 2^k-1 so the arithmetic shift truncates toward zero
  always_comb begin
    hbias = acc[ACC_W-1] ? ACC_W'((64'd1 << HFRAC) - 64'd1) : '0;
    obias = acc[ACC_W-1] ? ACC_W'((64'd1 << OFRAC) - 64'd1) : '0;
    hsum  = acc + hbias;
    osum  = acc + obias;
    hq    = hsum[ACC_W-1:HFRAC];
    oq    = osum[ACC_W-1:OFRAC];
  end

  // Saturate: value fits when all bits above the sign agree with it
  always_comb begin
    if ((&hq[HQ_W-1:HIST_W-1]) || !(|hq[HQ_W-1:HIST_W-1])) begin
      res.hist = hq[HIST_W-1:0];
    end else begin
      res.hist = hq[HQ_W-1] ? {1'b1, {(HIST_W-1){1'b0}}} : {1'b0, {(HIST_W-1){1'b1}}};
    end
    if ((&oq[OQ_W-1:SMP_W-1]) || !(|oq[OQ_W-1:SMP_W-1])) begin
      res.y = oq[SMP_W-1:0];
    end else begin
      res.y = oq[OQ_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    end
  end

endmodule

// ----- hw/rtl/iir_filter_direct_form_one.sv -----
// Top level of the direct form I IIR filter: config, taps, datapath, history.
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+-------------------
//  input    | in_sample_in, in_block_end_in              | in_valid / in_stall
//  result   | out_sample_out, out_block_end_out          | out_valid / out_stall
//  config   | cfg_index, cfg_data                        | cfg_we, no wait
//
// A request is taken into the input register; tap products, sum and
// truncate/saturate are combinational into the result register, which drives
// out_valid; a request is taken every cycle while no stalled result blocks it.
// Unless bypassed, the history shifts as the result register loads, in time for the next request.
// rst_n (synchronous) empties both registers, clears both histories and resets the config.
// A stalled result holds the result register; the next request then waits in
// the input register and in_stall follows out_stall until the result leaves.
module iir_filter_direct_form_one #(
  parameter int MAX_ORDER = 2
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] in_sample_in,
  input  logic                                  in_block_end_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [iirdf1_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic                                  out_block_end_out,
  input  logic                                  cfg_we,
  input  logic [iirdf1_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [iirdf1_pkg::COEF_W-1:0]         cfg_data
);

  localparam int SAMPLE_W = iirdf1_pkg::SAMPLE_W;
  localparam int COEF_W   = iirdf1_pkg::COEF_W;
  localparam int HIST_W   = iirdf1_pkg::HIST_W;
  localparam int ORDER_W  = iirdf1_pkg::ORDER_W;
  localparam int FF_W     = iirdf1_pkg::FF_PROD_W;
  localparam int FB_W     = iirdf1_pkg::FB_PROD_W;
  localparam int ACC_W    = iirdf1_pkg::ACC_W;
  localparam int FF_SH    = iirdf1_pkg::FF_SHIFT;
  localparam int NTAPS    = iirdf1_pkg::NUM_TAPS;

  // Configuration registers
  logic                     bypass_r;
  logic [ORDER_W-1:0]       order_r;
  logic signed [COEF_W-1:0] ff_coef_r [NTAPS];
  logic signed [COEF_W-1:0] fb_coef_r [1:NTAPS-1];
  logic                     cfg_hit;

  // History shift registers
  logic signed [SAMPLE_W-1:0] xh_r [MAX_ORDER];
  logic signed [HIST_W-1:0]   yh_r [MAX_ORDER];

  // Input register
  logic                       inp_valid_r;
  logic signed [SAMPLE_W-1:0] inp_x_r;
  logic                       inp_blk_r;

  // Single-pass datapath
  logic signed [FF_W-1:0]     ff_prod [MAX_ORDER+1];
  logic signed [FB_W-1:0]     fb_prod [1:MAX_ORDER];
  iirdf1_pkg::acc_t           acc_sum;
  iirdf1_pkg::sat_res_t       sat;

  // Result register
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_blk_r;

  logic                       in_acc;
  logic                       out_load;
  logic [ORDER_W-1:0]         order_eff;

  // Input waits only while a stalled result blocks the result register
  assign out_load = inp_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = inp_valid_r && !out_load;
  assign in_acc   = in_valid && !in_stall;

  // Orders above the build depth saturate
  assign order_eff = (order_r > ORDER_W'(MAX_ORDER)) ? ORDER_W'(MAX_ORDER) : order_r;

  // Known register index; unknown ones are ignored and keep the history
  assign cfg_hit = cfg_we && (cfg_index <= iirdf1_pkg::CFG_FB_COEF_2);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r     <= 1'b0;
      order_r      <= '0;
      ff_coef_r[0] <= iirdf1_pkg::FF_COEF_0_RST;
      ff_coef_r[1] <= '0;
      ff_coef_r[2] <= '0;
      fb_coef_r[1] <= '0;
      fb_coef_r[2] <= '0;
    end else if (cfg_we) begin
      case (iirdf1_pkg::cfg_idx_t'(cfg_index))
        iirdf1_pkg::CFG_BYPASS:       bypass_r     <= cfg_data[0];
        iirdf1_pkg::CFG_FILTER_ORDER: order_r      <= cfg_data[ORDER_W-1:0];
        iirdf1_pkg::CFG_FF_COEF_0:    ff_coef_r[0] <= cfg_data;
        iirdf1_pkg::CFG_FF_COEF_1:    ff_coef_r[1] <= cfg_data;
        iirdf1_pkg::CFG_FF_COEF_2:    ff_coef_r[2] <= cfg_data;
        iirdf1_pkg::CFG_FB_COEF_1:    fb_coef_r[1] <= cfg_data;
        iirdf1_pkg::CFG_FB_COEF_2:    fb_coef_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: holds a request until the result register takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inp_valid_r <= 1'b0;
    end else if (in_acc) begin
      inp_valid_r <= 1'b1;
    end else if (out_load) begin
      inp_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      inp_x_r   <= in_sample_in;
      inp_blk_r <= in_block_end_in;
    end
  end

  // Tap products, taps above the order contribute zero
  always_comb begin
    ff_prod[0] = inp_x_r * ff_coef_r[0];
    for (int j = 1; j <= MAX_ORDER; j++) begin
      if (ORDER_W'(j) <= order_eff) begin
        ff_prod[j] = xh_r[j-1] * ff_coef_r[j];
        fb_prod[j] = yh_r[j-1] * fb_coef_r[j];
      end else begin
        ff_prod[j] = '0;
        fb_prod[j] = '0;
      end
    end
  end

  // Sum at 22 fractional bits
  always_comb begin
    acc_sum = {{(ACC_W-FF_W-FF_SH){ff_prod[0][FF_W-1]}}, ff_prod[0], {FF_SH{1'b0}}};
    for (int j = 1; j <= MAX_ORDER; j++) begin
      acc_sum = acc_sum
              + {{(ACC_W-FF_W-FF_SH){ff_prod[j][FF_W-1]}}, ff_prod[j], {FF_SH{1'b0}}}
              + {{(ACC_W-FB_W){fb_prod[j][FB_W-1]}}, fb_prod[j]};
    end
  end

  // Truncate and saturate
  iirdf1_sat u_sat (
    .acc (acc_sum),
    .res (sat)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= bypass_r ? inp_x_r : sat.y;
      out_blk_r    <= inp_blk_r;
    end
  end

  // History: cleared on reset and known config writes, shifts on filtered requests
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      for (int j = 0; j < MAX_ORDER; j++) begin
        xh_r[j] <= '0;
        yh_r[j] <= '0;
      end
    end else if (out_load && !bypass_r) begin
      for (int j = MAX_ORDER - 1; j > 0; j--) begin
        xh_r[j] <= xh_r[j-1];
        yh_r[j] <= yh_r[j-1];
      end
      xh_r[0] <= inp_x_r;
      yh_r[0] <= sat.hist;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_sample_out    = out_sample_r;
  assign out_block_end_out = out_blk_r;

endmodule

// ----- hw/rtl/iirdf1_checker.sv -----
// Port-level checks of the IIR filter and the bind that attaches them.
module iirdf1_checker (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_stall,
  input logic                                   out_valid,
  input logic                                   out_stall,
  input logic signed [iirdf1_pkg::SAMPLE_W-1:0] out_sample_out,
  input logic                                   out_block_end_out
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_out)
                                  && $stable(out_block_end_out)))
    else $error("stalled result changed");

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // The input is held off only behind a stalled result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A new result comes from a request accepted through the input register
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without request in flight");

endmodule

bind iir_filter_direct_form_one iirdf1_checker u_iirdf1_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_sample_out    (out_sample_out),
  .out_block_end_out (out_block_end_out)
);

// ----- tb/iir_filter_direct_form_one_tb.sv -----
// Self-checking testbench for the direct form I IIR filter: directed table, then random phases.
module iir_filter_direct_form_one_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COEF_W    = iirdf1_pkg::COEF_W;
  localparam int CFG_IDX_W = iirdf1_pkg::CFG_IDX_W;
  localparam int ORDER_W   = iirdf1_pkg::ORDER_W;

  typedef iirdf1_pkg::sample_t  sample_t;
  typedef iirdf1_pkg::hist_t    hist_t;
  typedef iirdf1_pkg::cfg_idx_t cfg_idx_t;

  localparam int LAT_CYCLES = 2;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 40;
  localparam int MAX_WAIT = 12;
  localparam int DIR_ROWS = 40;
  localparam int MAX_SHOWN = 10;
  // Index past the last register; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  // One line of the directed table: a register write or a sample
  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [COEF_W-1:0]    reg_data;
    sample_t              x;
    logic                 blk;
    logic                 ref_ok;
    sample_t              y_ref;
  } dir_row_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [COEF_W-1:0]    data;
  } reg_wr_t;

  typedef struct packed {
    sample_t y;
    logic    blk;
  } filt_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sample_t in_sample_in = '0;
  logic in_block_end_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  sample_t out_sample_out;
  logic out_block_end_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;

  // Filter settings and histories as the block should hold them
  logic    m_passthru;
  logic [ORDER_W-1:0] m_order;
  coef_t   m_ff [0:2];
  coef_t   m_fb [1:2];
  sample_t m_x_hist [0:1];
  hist_t   m_y_hist [0:1];

  filt_out_t expected_out [$];
  dir_row_t  dir_tab [0:DIR_ROWS-1];

  int n_checked = 0;
  int n_errors = 0;
  int n_writes = 0;
  int n_settings = 0;
  int unsigned sink_wait = 0;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;
  filt_out_t got_item;
  filt_out_t want_item;

  iir_filter_direct_form_one #(.MAX_ORDER(2)) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_in     (in_sample_in),
    .in_block_end_in  (in_block_end_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_out   (out_sample_out),
    .out_block_end_out(out_block_end_out),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void clear_history();
    m_x_hist[0] = '0;
    m_x_hist[1] = '0;
    m_y_hist[0] = '0;
    m_y_hist[1] = '0;
  endfunction

  // Register write as the block sees it; spare index leaves everything alone
  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] d);
    if (idx > iirdf1_pkg::CFG_FB_COEF_2) return;
    case (cfg_idx_t'(idx))
      iirdf1_pkg::CFG_BYPASS:       m_passthru = d[0];
      iirdf1_pkg::CFG_FILTER_ORDER: m_order = d[ORDER_W-1:0];
      iirdf1_pkg::CFG_FF_COEF_0:    m_ff[0] = d;
      iirdf1_pkg::CFG_FF_COEF_1:    m_ff[1] = d;
      iirdf1_pkg::CFG_FF_COEF_2:    m_ff[2] = d;
      iirdf1_pkg::CFG_FB_COEF_1:    m_fb[1] = d;
      iirdf1_pkg::CFG_FB_COEF_2:    m_fb[2] = d;
      default: ;
    endcase
    clear_history();
  endfunction

  // One filter step: Q.22 accumulation, truncation toward zero, saturation
  function automatic sample_t filter_sample(sample_t x);
    longint acc;
    longint hist_v;
    longint y_v;
    int eff;
    if (m_passthru) return x;
    eff = (m_order > 2) ? 2 : int'(m_order);
    acc = longint'(x) * longint'(m_ff[0]) * 256;
    for (int j = 1; j <= eff; j++) begin
      acc += longint'(m_x_hist[j-1]) * longint'(m_ff[j]) * 256;
      acc += longint'(m_y_hist[j-1]) * longint'(m_fb[j]);
    end
    hist_v = acc / 16384;
    if (hist_v > 64'sd2147483647) hist_v = 64'sd2147483647;
    if (hist_v < -64'sd2147483648) hist_v = -64'sd2147483648;
    y_v = acc / 4194304;
    if (y_v > 32767) y_v = 32767;
    if (y_v < -32768) y_v = -32768;
    // delay lines always shift at full depth
    m_x_hist[1] = m_x_hist[0];
    m_y_hist[1] = m_y_hist[0];
    m_x_hist[0] = x;
    m_y_hist[0] = hist_t'(hist_v);
    return sample_t'(y_v);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Modest coefficients half the time so the filter stays in range, else full-range or extreme
  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 3))
      0: return COEF_W'($urandom_range(0, 262143));
      1: return $urandom_range(0, 1) ? 18'h1FFFF : 18'h20000;
      default: return COEF_W'(int'($urandom_range(0, 16384)) - 8192);
    endcase
  endfunction

  // Result side: random stall after each accepted result
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_wait = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sink_wait = sink_quiet ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (sink_wait != 0) begin
        sink_wait--;
      end
      out_stall <= (sink_wait != 0);
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_item = '{y: out_sample_out, blk: out_block_end_out};
      if (expected_out.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("tb: result with none pending: y=%0d blk=%0b", got_item.y, got_item.blk);
      end else begin
        want_item = expected_out.pop_front();
        if (got_item.y !== want_item.y || got_item.blk !== want_item.blk) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("tb: mismatch at result %0d: expected y=%0d blk=%0b, got y=%0d blk=%0b",
                     n_checked, want_item.y, want_item.blk, got_item.y, got_item.blk);
        end
        n_checked++;
      end
    end
  end

  // Present one request after a random gap and wait until it is taken
  task automatic send_sample(sample_t x, logic blk, logic ref_ok, sample_t y_ref);
    int unsigned gap;
    sample_t y;
    gap = src_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= x;
    in_block_end_in <= blk;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    y = filter_sample(x);
    expected_out.push_back('{y: ref_ok ? y_ref : y, blk: blk});
  endtask

  // Hold off until every pending result is out and the pipeline is empty
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  task automatic write_batch(input reg_wr_t wr_list[$]);
    wait_drained();
    foreach (wr_list[k]) begin
      cfg_we <= 1'b1;
      cfg_index <= wr_list[k].idx;
      cfg_data <= wr_list[k].data;
      @(posedge clk);
      apply_reg(wr_list[k].idx, wr_list[k].data);
      n_writes++;
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    reg_wr_t batch [$];
    int i;
    logic [COEF_W-1:0] fill;

    // Reset state of the filter
    m_passthru = 1'b0;
    m_order = '0;
    m_ff[0] = iirdf1_pkg::FF_COEF_0_RST;
    m_ff[1] = '0;
    m_ff[2] = '0;
    m_fb[1] = '0;
    m_fb[2] = '0;
    clear_history();

    // Directed table: reset passthrough, gain extremes, bypass, full filter,
    // spare index, order above max, history saturation
    dir_tab = '{
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sd0,     1'b0, 1'b1, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh7FFF,  1'b1, 1'b1, 16'sh7FFF},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh8000,  1'b0, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 3'd0, 18'd0, -16'sd1,    1'b1, 1'b1, -16'sd1},
      '{ROW_WRITE, iirdf1_pkg::CFG_FF_COEF_0, 18'h1FFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh7FFF,  1'b0, 1'b1, 16'sh7FFF},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh8000,  1'b1, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sd1,     1'b0, 1'b1, 16'sd7},
      '{ROW_SAMPLE, 3'd0, 18'd0, -16'sd1,    1'b1, 1'b1, -16'sd7},
      '{ROW_WRITE, iirdf1_pkg::CFG_FF_COEF_0, 18'h20000, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh8000,  1'b0, 1'b1, 16'sh7FFF},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh7FFF,  1'b1, 1'b1, 16'sh8000},
      '{ROW_WRITE, iirdf1_pkg::CFG_BYPASS, 18'h3FFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh8000,  1'b1, 1'b1, 16'sh8000},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sd12345, 1'b0, 1'b1, 16'sd12345},
      '{ROW_WRITE, iirdf1_pkg::CFG_BYPASS,       18'h00000, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FF_COEF_0,    18'd16384, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FF_COEF_1,    18'd8192,  16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FF_COEF_2,    18'h3F000, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FB_COEF_1,    18'd8192,  16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FB_COEF_2,    18'h3F800, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FILTER_ORDER, 18'd2,     16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sd20000,  1'b1, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, -16'sd15000, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh7FFF,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh8000,   1'b1, 1'b0, 16'sd0},
      '{ROW_WRITE, CFG_IDX_SPARE, 18'h3FFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sd1000,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, -16'sd1000,  1'b1, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FILTER_ORDER, 18'h3FFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh7FFF,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sd0,      1'b1, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FF_COEF_0,    18'h1FFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FB_COEF_1,    18'h1FFFF, 16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, iirdf1_pkg::CFG_FILTER_ORDER, 18'd1,     16'sd0, 1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh7FFF,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh7FFF,   1'b1, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh7FFF,   1'b0, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh7FFF,   1'b1, 1'b0, 16'sd0},
      '{ROW_SAMPLE, 3'd0, 18'd0, 16'sh8000,   1'b0, 1'b0, 16'sd0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; consecutive writes go out as one batch
    i = 0;
    while (i < DIR_ROWS) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        batch = {};
        while (i < DIR_ROWS && dir_tab[i].kind == ROW_WRITE) begin
          batch.push_back('{idx: dir_tab[i].reg_idx, data: dir_tab[i].reg_data});
          i++;
        end
        write_batch(batch);
      end else begin
        send_sample(dir_tab[i].x, dir_tab[i].blk, dir_tab[i].ref_ok, dir_tab[i].y_ref);
        i++;
      end
    end

    // Random phases, each with its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      batch = {};
      fill = COEF_W'($urandom);
      case (ph)
        0: begin
          // everything at the positive extreme, order field all ones
          batch.push_back('{idx: iirdf1_pkg::CFG_BYPASS, data: fill & ~18'h1});
          batch.push_back('{idx: iirdf1_pkg::CFG_FILTER_ORDER, data: 18'h3});
          for (int r = iirdf1_pkg::CFG_FF_COEF_0;
               r <= iirdf1_pkg::CFG_FB_COEF_2; r++)
            batch.push_back('{idx: CFG_IDX_W'(r), data: 18'h1FFFF});
        end
        1: begin
          batch.push_back('{idx: iirdf1_pkg::CFG_BYPASS, data: 18'h0});
          batch.push_back('{idx: iirdf1_pkg::CFG_FILTER_ORDER, data: 18'h2});
          for (int r = iirdf1_pkg::CFG_FF_COEF_0;
               r <= iirdf1_pkg::CFG_FB_COEF_2; r++)
            batch.push_back('{idx: CFG_IDX_W'(r), data: 18'h20000});
        end
        default: begin
          batch.push_back('{idx: iirdf1_pkg::CFG_BYPASS,
                            data: (fill & ~18'h1) | ((ph == 2 || $urandom_range(0, 5) == 0)
                                                     ? 18'h1 : 18'h0)});
          batch.push_back('{idx: iirdf1_pkg::CFG_FILTER_ORDER,
                            data: (COEF_W'($urandom) & ~18'h3) | COEF_W'($urandom_range(0, 3))});
          for (int r = iirdf1_pkg::CFG_FF_COEF_0;
               r <= iirdf1_pkg::CFG_FB_COEF_2; r++)
            batch.push_back('{idx: CFG_IDX_W'(r), data: rand_coef()});
        end
      endcase
      if (ph % 3 == 2) batch.push_back('{idx: CFG_IDX_SPARE, data: COEF_W'($urandom)});
      src_quiet = (ph % 4 == 3);
      sink_quiet = (ph % 5 == 1);
      write_batch(batch);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // sender holds back once until the pipeline has fully drained
        if (ph == 4 && k == PHASE_ITEMS / 2) wait_drained();
        send_sample(rand_sample(), 1'($urandom_range(0, 1)), 1'b0, 16'sd0);
      end
    end

    wait_drained();
    $display("tb: %0d filtered samples checked across %0d register settings (%0d writes)",
             n_checked, n_settings, n_writes);
    $display("tb: covered bypass, orders 0..3, coefficient extremes and history saturation");
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/iirdf1_pkg.sv
hw/rtl/iirdf1_sat.sv
hw/rtl/iir_filter_direct_form_one.sv
hw/rtl/iirdf1_checker.sv
tb/iir_filter_direct_form_one_tb.sv
